// File: sv/dow_pkg.sv
package dow_pkg;

  // Stage 1: the year is split into its century and the year within it.
  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic [1:0] cent_lo;   // century number modulo 4
    logic [6:0] yy;        // year within the century, 0..99
    logic [1:0] yr_lo;     // year modulo 4
  } dow_s1_t;

  // Stage 2: leap rule, date check and the year within the century split by 12.
  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic       leap;
    logic       date_ok;
    logic [1:0] cent_lo;
    logic [3:0] q12;       // 0..8
    logic [3:0] r12;       // 0..11
  } dow_s2_t;

  // Stage 3: anchor weekday and the distance term of the month's doomsday date.
  typedef struct packed {
    logic [4:0] day;
    logic       leap;
    logic       date_ok;
    logic [2:0] anchor;
    logic [5:0] dd_gap;    // 35 minus the month's doomsday date
  } dow_s3_t;

  localparam logic [6:0] YearsPerCentury = 7'd100;
  localparam logic [3:0] MonthsPerYear   = 4'd12;
  localparam logic [2:0] DaysPerWeek     = 3'd7;
  localparam logic [5:0] WeekFold        = 6'd35;
  localparam logic [12:0] Recip100       = 13'd5243;  // 2^19 / 100, rounded up
  localparam int unsigned Recip100Shift  = 19;
  localparam logic [5:0] Recip12         = 6'd43;     // 2^9 / 12, rounded up
  localparam int unsigned Recip12Shift   = 9;
  localparam logic [5:0] Recip7          = 6'd37;     // 2^8 / 7, rounded up
  localparam int unsigned Recip7Shift    = 8;

  function automatic logic [2:0] century_code(input logic [1:0] cent_lo);
    logic [2:0] code;
    case (cent_lo)
      2'd0:    code = 3'd2;
      2'd1:    code = 3'd0;
      2'd2:    code = 3'd5;
      default: code = 3'd3;
    endcase
    return code;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Day of the month that falls on the year's doomsday.
  function automatic logic [4:0] month_dd(input logic [3:0] month, input logic leap);
    logic [4:0] dd;
    case (month)
      4'd1:    dd = leap ? 5'd4 : 5'd3;
      4'd2:    dd = leap ? 5'd29 : 5'd28;
      4'd3:    dd = 5'd14;
      4'd4:    dd = 5'd4;
      4'd5:    dd = 5'd9;
      4'd6:    dd = 5'd6;
      4'd7:    dd = 5'd11;
      4'd8:    dd = 5'd8;
      4'd9:    dd = 5'd5;
      4'd10:   dd = 5'd10;
      4'd11:   dd = 5'd7;
      4'd12:   dd = 5'd12;
      default: dd = 5'd0;
    endcase
    return dd;
  endfunction

  // Reduces a value below 28 modulo 7 with one compare-subtract choice.
  function automatic logic [2:0] mod7_small(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd21) begin
      r = v - 5'd21;
    end else if (v >= 5'd14) begin
      r = v - 5'd14;
    end else if (v >= 5'd7) begin
      r = v - 5'd7;
    end else begin
      r = v;
    end
    return r[2:0];
  endfunction

endpackage

// File: sv/dow_yr_split.sv
module dow_yr_split (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [3:0]      month_num,
  input  logic [4:0]      day_of_month,
  input  logic [13:0]     year_num,
  output logic            out_vld,
  output dow_pkg::dow_s1_t out_data
);
  import dow_pkg::*;

  logic [26:0] prod;
  logic [7:0]  cent;
  logic [13:0] cent_years;
  logic [13:0] rem;

  // The reciprocal is exact for every 14-bit year.
  assign prod       = 27'(year_num) * 27'(Recip100);
  assign cent       = prod[Recip100Shift +: 8];
  assign cent_years = 14'(cent) * 14'(YearsPerCentury);
  assign rem        = year_num - cent_years;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_data.month   <= month_num;
      out_data.day     <= day_of_month;
      out_data.cent_lo <= cent[1:0];
      out_data.yy      <= rem[6:0];
      out_data.yr_lo   <= year_num[1:0];
    end
  end

endmodule

// File: sv/dow_leap_check.sv
module dow_leap_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  dow_pkg::dow_s1_t in_data,
  output logic            out_vld,
  output dow_pkg::dow_s2_t out_data
);
  import dow_pkg::*;

  logic        leap;
  logic        date_ok;
  logic [12:0] prod;
  logic [3:0]  q12;
  logic [6:0]  r12;

  // A year is leap when divisible by 4, unless it ends a century not divisible by 400.
  assign leap = (in_data.yr_lo == 2'd0) &&
                ((in_data.yy != 7'd0) || (in_data.cent_lo == 2'd0));

  assign date_ok = (in_data.month >= 4'd1) && (in_data.month <= MonthsPerYear) &&
                   (in_data.day != 5'd0) &&
                   (in_data.day <= month_len(in_data.month, leap));

  assign prod = 13'(in_data.yy) * 13'(Recip12);
  assign q12  = prod[Recip12Shift +: 4];
  assign r12  = in_data.yy - (7'(q12) * 7'(MonthsPerYear));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_data.month   <= in_data.month;
      out_data.day     <= in_data.day;
      out_data.leap    <= leap;
      out_data.date_ok <= date_ok;
      out_data.cent_lo <= in_data.cent_lo;
      out_data.q12     <= q12;
      out_data.r12     <= r12[3:0];
    end
  end

endmodule

// File: sv/dow_anchor.sv
module dow_anchor (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  dow_pkg::dow_s2_t in_data,
  output logic            out_vld,
  output dow_pkg::dow_s3_t out_data
);
  import dow_pkg::*;

  logic [4:0] sum;
  logic [4:0] dd;

  assign sum = 5'(century_code(in_data.cent_lo)) + 5'(in_data.q12) +
               5'(in_data.r12) + 5'(in_data.r12[3:2]);
  assign dd  = month_dd(in_data.month, in_data.leap);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_data.day     <= in_data.day;
      out_data.leap    <= in_data.leap;
      out_data.date_ok <= in_data.date_ok;
      out_data.anchor  <= mod7_small(sum);
      out_data.dd_gap  <= WeekFold - 6'(dd);
    end
  end

endmodule

// File: sv/day_of_week_doomsday.sv
// Gregorian day of week by the doomsday rule. Each accepted item carries a
// month, a day and a year; each gives exactly one result item with the
// weekday of the date (0 = Sunday), the year's doomsday weekday, a leap-year
// flag and a flag that the month and day form an existing date. A date that
// does not exist (month outside 1..12, day 0, or a day past the month's end,
// February included) reports weekday 0, while the doomsday weekday and leap
// flag are still computed from the year. The block is a four-stage pipeline:
// split of the year into century and year within it, leap rule and date
// check, doomsday weekday, and the final weekday in the output register.
// A new item can be accepted every cycle while req_stall is low, and each item
// moves through the stage registers in order to the output register.
// A stall only holds the stages that are occupied, so empty stages keep filling.
module day_of_week_doomsday (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [3:0]  month_num,
  input  logic [4:0]  day_of_month,
  input  logic [13:0] year_num,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  weekday,
  output logic [2:0]  anchor_weekday,
  output logic        is_leap,
  output logic        date_valid
);
  import dow_pkg::*;

  dow_s1_t s1_data;
  dow_s2_t s2_data;
  dow_s3_t s3_data;
  logic    s1_vld;
  logic    s2_vld;
  logic    s3_vld;

  // Each stage loads when it is empty or when the stage after it loads.
  logic en1;
  logic en2;
  logic en3;
  logic en4;

  assign en4       = !rsp_valid || !rsp_stall;
  assign en3       = !s3_vld || en4;
  assign en2       = !s2_vld || en3;
  assign en1       = !s1_vld || en2;
  assign req_stall = !en1;

  dow_yr_split u_yr_split (
    .clk          (clk),
    .rst          (rst),
    .en           (en1),
    .in_vld       (req_valid),
    .month_num    (month_num),
    .day_of_month (day_of_month),
    .year_num     (year_num),
    .out_vld      (s1_vld),
    .out_data     (s1_data)
  );

  dow_leap_check u_leap_check (
    .clk      (clk),
    .rst      (rst),
    .en       (en2),
    .in_vld   (s1_vld),
    .in_data  (s1_data),
    .out_vld  (s2_vld),
    .out_data (s2_data)
  );

  dow_anchor u_anchor (
    .clk      (clk),
    .rst      (rst),
    .en       (en3),
    .in_vld   (s2_vld),
    .in_data  (s2_data),
    .out_vld  (s3_vld),
    .out_data (s3_data)
  );

  // The weekday is the anchor moved by the day's distance from the month's
  // doomsday date. The constant 35 keeps the sum positive; the sum stays
  // below 73, where the reciprocal multiply gives the exact quotient by 7.
  logic [6:0]  wd_sum;
  logic [12:0] wd_prod;
  logic [3:0]  wd_quot;
  logic [6:0]  wd_rem;

  assign wd_sum  = 7'(s3_data.anchor) + 7'(s3_data.day) + 7'(s3_data.dd_gap);
  assign wd_prod = 13'(wd_sum) * 13'(Recip7);
  assign wd_quot = wd_prod[Recip7Shift +: 4];
  assign wd_rem  = wd_sum - (7'(wd_quot) * 7'(DaysPerWeek));

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en4) begin
      rsp_valid <= s3_vld;
    end
    if (en4) begin
      weekday        <= s3_data.date_ok ? wd_rem[2:0] : 3'd0;
      anchor_weekday <= s3_data.anchor;
      is_leap        <= s3_data.leap;
      date_valid     <= s3_data.date_ok;
    end
  end

endmodule
